>>> hw/rtl/floppy_mailbox_command_engine_macros.svh
// ----------------------------------------------------------------------------
// Mailbox command engine assertion macros
// Short forms for clocked properties on clk with rst as the disable.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_MAILBOX_COMMAND_ENGINE_MACROS_SVH
`define FLOPPY_MAILBOX_COMMAND_ENGINE_MACROS_SVH

// same-cycle implication
`define FMCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fmce_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox command engine package
// Item types, command codes, status bytes and mailbox byte addresses.
// ----------------------------------------------------------------------------
`default_nettype none

package fmce_pkg;

  localparam int unsigned RamBytesDef = 1024;
  localparam int unsigned IdxW        = 15;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] CfgCompleteDelay = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDiskRomId     = 2'd1;

  localparam logic [15:0] CompleteDelayRst = 16'd24000;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_EJECT  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_DONE   = 3'd5
  } cmd_t;

  // mailbox command bytes
  localparam logic [7:0] MbExec    = 8'h81;
  localparam logic [7:0] MbStatClr = 8'h83;
  localparam logic [7:0] MbClrSix  = 8'h84;
  localparam logic [7:0] MbIrqClr  = 8'h85;
  localparam logic [7:0] MbIrqSet  = 8'h88;

  // execute sub-commands
  localparam logic [7:0] SubRead  = 8'h00;
  localparam logic [7:0] SubWrite = 8'h01;
  localparam logic [7:0] SubEject = 8'h02;
  localparam logic [7:0] SubRdTag = 8'h07;

  // status byte values
  localparam logic [7:0] StOk      = 8'h00;
  localparam logic [7:0] StNoDisk  = 8'h16;
  localparam logic [7:0] StBadAddr = 8'h17;
  localparam logic [7:0] StWrFail  = 8'h18;

  localparam logic [7:0] EvInsert  = 8'h0C;
  localparam logic [7:0] SweepB196 = 8'h10;
  localparam logic [7:0] SweepB254 = 8'hFE;
  localparam logic [7:0] MaxTrack  = 8'd79;
  localparam logic [7:0] ZoneBase  = 8'd12;

  // mailbox byte addresses
  localparam int unsigned AdrCmd    = 0;
  localparam int unsigned AdrSub    = 1;
  localparam int unsigned AdrCtl    = 2;
  localparam int unsigned AdrSide   = 3;
  localparam int unsigned AdrSector = 4;
  localparam int unsigned AdrTrack  = 5;
  localparam int unsigned AdrSix    = 6;
  localparam int unsigned AdrStatus = 8;
  localparam int unsigned AdrMedia  = 10;
  localparam int unsigned AdrRomId  = 24;
  localparam int unsigned AdrPresent = 32;
  localparam int unsigned AdrEvent  = 47;
  localparam int unsigned AdrB196   = 196;
  localparam int unsigned AdrB254   = 254;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] bus_offset;
    logic [7:0]  write_data;
    logic        two_sided;
    logic        transfer_ok;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       disk_request;
    logic       request_write;
    logic [6:0] request_track;
    logic       request_side;
    logic [3:0] request_sector;
    logic       media_present;
  } out_t;

  // classified item handed from front to engine
  typedef struct packed {
    cmd_t            cmd;
    logic [IdxW-1:0] idx;
    logic            oor;
    logic [7:0]      wd;
    logic            two;
    logic            ok;
    logic            run;
  } cls_t;

endpackage

`default_nettype wire

>>> hw/rtl/fmce_front.sv
// ----------------------------------------------------------------------------
// Mailbox command engine front end
// Accept items, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fmce_front
  import fmce_pkg::*;
#(
  parameter int unsigned RAM_BYTES = RamBytesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  input  wire logic sweeping,
  output logic      q_valid,
  input  wire logic q_pop,
  output cls_t      q_item
);

  cls_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cls_t       cls;

  always_comb begin
    cls.cmd = cmd_t'(in_item.cmd);
    cls.idx = in_item.bus_offset[15:1];
    cls.oor = {1'b0, in_item.bus_offset[15:1]} >= 16'(RAM_BYTES);
    cls.wd  = in_item.write_data;
    cls.two = in_item.two_sided;
    cls.ok  = in_item.transfer_ok;
    cls.run = (cmd_t'(in_item.cmd) == CMD_WRITE) && (in_item.bus_offset[15:1] == '0) &&
              (in_item.write_data != 8'h00);
  end

  assign in_ready = (count != 2'd2) && !sweeping;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fmce_engine.sv
// ----------------------------------------------------------------------------
// Mailbox command engine back end
// Run items against the shared RAM, keep timer and drive state, present results.
// ----------------------------------------------------------------------------
`default_nettype none

module fmce_engine
  import fmce_pkg::*;
#(
  parameter int unsigned RAM_BYTES = RamBytesDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire cls_t                q_item,
  output logic                     q_pop,
  output logic                     sweeping,
  input  wire logic                cfg_valid,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_t                     out_item
);

  localparam int unsigned AW = $clog2(RAM_BYTES);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_RDW, S_XA, S_XB, S_XC, S_XD, S_XE,
    S_TA, S_TB, S_WR, S_OR, S_FIN
  } state_t;

  state_t state;

  logic [7:0] ram [RAM_BYTES];
  logic [7:0] ram_q;
  logic       we;
  logic       re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0] wdata;

  logic [AW-1:0] sweep_cnt;
  logic [11:0]   sweep_wide;
  logic [7:0]    sweep_val;

  logic [15:0] delay;
  logic [7:0]  rom_id;
  logic        rom_pend;

  logic        irq, disk_in, disk_double, pending, piw;
  logic [15:0] ccount;

  logic        f10, f32, f6, f8, f47, f0, f_or;
  logic [7:0]  v8, orv;
  logic [7:0]  b1, b4;
  logic        b3;
  logic        oor_r;
  logic [7:0]  res_rd;

  logic        rq_valid, rq_write, rq_side;
  logic [6:0]  rq_track;
  logic [3:0]  rq_sector;

  logic [7:0]  media10, media32, ev, zone, done_val;
  logic        fire, bad, idle_take, fin, deliver, out_free;
  logic [7:0]  fin_byte;
  out_t        res;

  assign sweeping   = (state == S_SWEEP);
  assign sweep_wide = 12'(sweep_cnt);
  assign out_free   = !out_valid || out_ready;
  assign idle_take  = (state == S_IDLE) && !rom_pend && q_valid;
  assign q_pop      = idle_take;
  assign media10    = disk_in ? (disk_double ? 8'h02 : 8'h01) : 8'h00;
  assign media32    = {7'd0, disk_in};
  assign fire       = pending && (ccount <= 16'd1);
  assign done_val   = q_item.ok ? StOk : (piw ? StWrFail : StBadAddr);
  // drive-encoded events: bit 7 of byte 2 lands on bits 7 and 6, bit 3 on bit 2
  assign ev         = (ram_q[7] || ram_q[3]) ? {ram_q[7], ram_q[7], 3'b000, ram_q[3], 2'b00}
                                             : EvInsert;
  assign zone       = ZoneBase - {4'd0, ram_q[7:4]};
  assign bad        = (ram_q > MaxTrack) || (b4 >= zone);

  always_comb begin
    if (sweep_wide == 12'(AdrRomId)) begin
      sweep_val = rom_id;
    end else if (sweep_wide == 12'(AdrB196)) begin
      sweep_val = SweepB196;
    end else if (sweep_wide == 12'(AdrB254)) begin
      sweep_val = SweepB254;
    end else begin
      sweep_val = 8'h00;
    end
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = 8'h00;
    case (state)
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_cnt;
        wdata = sweep_val;
      end
      S_IDLE: begin
        if (rom_pend) begin
          we    = 1'b1;
          waddr = AW'(AdrRomId);
          wdata = rom_id;
        end else if (q_valid) begin
          case (q_item.cmd)
            CMD_READ: begin
              re    = !q_item.oor;
              raddr = q_item.idx[AW-1:0];
            end
            CMD_WRITE: begin
              we    = !q_item.oor;
              waddr = q_item.idx[AW-1:0];
              wdata = q_item.wd;
            end
            CMD_DONE: begin
              we    = 1'b1;
              waddr = AW'(AdrStatus);
              wdata = done_val;
            end
            default: ;
          endcase
        end
      end
      S_XA: begin re = 1'b1; raddr = AW'(AdrSub); end
      S_XB: begin re = 1'b1; raddr = AW'(AdrSide); end
      S_XC: begin re = 1'b1; raddr = AW'(AdrSector); end
      S_XD: begin re = 1'b1; raddr = AW'(AdrTrack); end
      S_TA: begin re = 1'b1; raddr = AW'(AdrCtl); end
      S_WR: begin
        if (f10) begin
          we = 1'b1; waddr = AW'(AdrMedia); wdata = media10;
        end else if (f32) begin
          we = 1'b1; waddr = AW'(AdrPresent); wdata = media32;
        end else if (f6) begin
          we = 1'b1; waddr = AW'(AdrSix);
        end else if (f8) begin
          we = 1'b1; waddr = AW'(AdrStatus); wdata = v8;
        end else if (f47) begin
          we = 1'b1; waddr = AW'(AdrEvent);
        end else if (f0) begin
          we = 1'b1; waddr = AW'(AdrCmd);
        end else if (f_or) begin
          re = 1'b1; raddr = AW'(AdrEvent);
        end
      end
      S_OR: begin
        we    = 1'b1;
        waddr = AW'(AdrEvent);
        wdata = ram_q | orv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (re) begin
      ram_q <= ram[raddr];
    end
  end

  // item completion and result composition
  always_comb begin
    fin      = 1'b0;
    fin_byte = res_rd;
    case (state)
      S_IDLE: begin
        if (idle_take) begin
          case (q_item.cmd)
            CMD_WRITE: fin = !q_item.run;
            CMD_TICK:  fin = !fire;
            CMD_DONE:  fin = 1'b1;
            CMD_READ, CMD_INSERT, CMD_EJECT: fin = 1'b0;
            default:   fin = 1'b1;
          endcase
        end
      end
      S_RDW: begin
        fin      = 1'b1;
        fin_byte = oor_r ? 8'hFF : ram_q;
      end
      S_WR:  fin = !(f10 || f32 || f6 || f8 || f47 || f0 || f_or);
      S_OR:  fin = 1'b1;
      S_FIN: fin = 1'b1;
      default: fin = 1'b0;
    endcase
    deliver = fin && out_free;

    res.read_data      = fin_byte;
    res.irq_line       = irq;
    res.disk_request   = rq_valid;
    res.request_write  = rq_valid && rq_write;
    res.request_track  = rq_valid ? rq_track : 7'd0;
    res.request_side   = rq_valid && rq_side;
    res.request_sector = rq_valid ? rq_sector : 4'd0;
    res.media_present  = disk_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_cnt <= '0;
      delay     <= CompleteDelayRst;
      rom_id    <= 8'h00;
      rom_pend  <= 1'b0;
      irq       <= 1'b0;
      disk_in   <= 1'b0;
      disk_double <= 1'b0;
      pending   <= 1'b0;
      piw       <= 1'b0;
      ccount    <= 16'd0;
      {f10, f32, f6, f8, f47, f0, f_or} <= '0;
      rq_valid  <= 1'b0;
      res_rd    <= 8'h00;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgCompleteDelay: delay <= cfg_data;
          CfgDiskRomId: begin
            rom_id   <= cfg_data[7:0];
            rom_pend <= 1'b1;
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == AW'(RAM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rom_pend) begin
            rom_pend <= cfg_valid && (cfg_index == CfgDiskRomId);
          end else if (q_valid) begin
            oor_r <= q_item.oor;
            case (q_item.cmd)
              CMD_READ: begin
                res_rd <= 8'hFF;
                state  <= S_RDW;
              end
              CMD_WRITE: begin
                if (q_item.run) begin
                  state <= S_WR;
                  f0    <= 1'b1;
                  case (q_item.wd)
                    MbExec: state <= S_XA;
                    MbStatClr: begin
                      f8 <= 1'b1; v8 <= StOk; irq <= 1'b1;
                    end
                    MbClrSix: begin
                      f6 <= 1'b1; f8 <= 1'b1; v8 <= StOk;
                    end
                    MbIrqClr: begin
                      f47 <= 1'b1; irq <= 1'b0;
                    end
                    MbIrqSet: irq <= 1'b1;
                    default: ;
                  endcase
                end
              end
              CMD_INSERT: begin
                disk_in     <= 1'b1;
                disk_double <= q_item.two;
                irq         <= 1'b1;
                f10 <= 1'b1; f32 <= 1'b1; f_or <= 1'b1; orv <= EvInsert;
                state <= S_WR;
              end
              CMD_EJECT: begin
                disk_in <= 1'b0;
                f10 <= 1'b1; f32 <= 1'b1; f47 <= 1'b1;
                state <= S_WR;
              end
              CMD_TICK: begin
                if (fire) begin
                  state <= S_TA;
                end else if (pending) begin
                  ccount <= ccount - 16'd1;
                end
              end
              default: ;
            endcase
          end
        end
        S_XA: state <= S_XB;
        S_XB: begin b1 <= ram_q; state <= S_XC; end
        S_XC: begin b3 <= ram_q[0]; state <= S_XD; end
        S_XD: begin b4 <= ram_q; state <= S_XE; end
        S_XE: begin
          // ram_q holds the track byte here
          if (!disk_in) begin
            f8 <= 1'b1; v8 <= StNoDisk;
          end else if (bad) begin
            f8 <= 1'b1; v8 <= StBadAddr;
          end else if (b1 == SubRead || b1 == SubRdTag || b1 == SubWrite) begin
            rq_valid  <= 1'b1;
            rq_write  <= (b1 == SubWrite);
            rq_track  <= ram_q[6:0];
            rq_side   <= b3;
            rq_sector <= b4[3:0];
            piw       <= (b1 == SubWrite);
          end else if (b1 == SubEject) begin
            disk_in <= 1'b0;
            f10 <= 1'b1; f32 <= 1'b1; f47 <= 1'b1; f8 <= 1'b1; v8 <= StOk;
          end else begin
            f8 <= 1'b1; v8 <= StOk;
          end
          ccount  <= delay;
          pending <= 1'b1;
          state   <= S_WR;
        end
        S_TA: state <= S_TB;
        S_TB: begin
          f_or    <= 1'b1;
          orv     <= ev;
          irq     <= 1'b1;
          pending <= 1'b0;
          ccount  <= 16'd0;
          state   <= S_WR;
        end
        S_WR: begin
          if (f10) begin
            f10 <= 1'b0;
          end else if (f32) begin
            f32 <= 1'b0;
          end else if (f6) begin
            f6 <= 1'b0;
          end else if (f8) begin
            f8 <= 1'b0;
          end else if (f47) begin
            f47 <= 1'b0;
          end else if (f0) begin
            f0 <= 1'b0;
          end else if (f_or) begin
            f_or  <= 1'b0;
            state <= S_OR;
          end
        end
        default: ;
      endcase

      // hold a finished result until the output register frees up
      if (fin) begin
        if (deliver) begin
          out_valid <= 1'b1;
          out_item  <= res;
          rq_valid  <= 1'b0;
          res_rd    <= 8'h00;
          state     <= S_IDLE;
        end else begin
          res_rd <= fin_byte;
          state  <= S_FIN;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/floppy_mailbox_command_engine.sv
// ----------------------------------------------------------------------------
// Floppy mailbox command engine
// Shared mailbox RAM with command decode, completion timer and disk requests.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_item): one item per bus access, drive
//     event, timer tick or transfer completion.
//   out channel (out_valid/out_ready/out_item): exactly one result per item,
//     in order: read byte, interrupt level, any sector request, media state.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//     only while no item is outstanding.
// Pacing: a bus read returns its byte from the registered RAM read in S_RDW;
//   the single-ported shared RAM paces every item, as every mailbox byte
//   a command touches is one RAM access.
// Reset: the shared RAM is cleared by a pass over all RAM_BYTES addresses, writing the
//   machine id and fixed bytes on the way; in_ready stays low until it ends.
// Stall: a result waits in the output register while the two-entry queue
//   keeps taking items; the engine holds when its next result cannot leave.
// ----------------------------------------------------------------------------
`default_nettype none

module floppy_mailbox_command_engine
  import fmce_pkg::*;
#(
  parameter int unsigned RAM_BYTES = RamBytesDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_t                 in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_t                     out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic q_valid;
  logic q_pop;
  cls_t q_item;
  logic sweeping;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  // classify and queue incoming items
  fmce_front #(
    .RAM_BYTES(RAM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .sweeping (sweeping),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // execute items against the shared RAM and drive the result register
  fmce_engine #(
    .RAM_BYTES(RAM_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .sweeping  (sweeping),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fmce_checker.sv
// ----------------------------------------------------------------------------
// Mailbox command engine checker
// Port-level properties of results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "floppy_mailbox_command_engine_macros.svh"

module fmce_checker
  import fmce_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire out_t                out_item
);

  `FMCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_item), "result changed while stalled")

  `FMCE_ASSERT_IMP(a_req_addr, out_valid && out_item.disk_request,
    out_item.request_track < 7'd80 && out_item.request_sector < 4'd12,
    "sector request outside the disk geometry")

  `FMCE_ASSERT_IMP(a_req_media, out_valid && out_item.disk_request,
    out_item.media_present, "sector request with no disk in the drive")

  `FMCE_ASSERT_IMP(a_req_idle, out_valid && !out_item.disk_request,
    !out_item.request_write && out_item.request_track == 7'd0 &&
    !out_item.request_side && out_item.request_sector == 4'd0,
    "request fields set without a request")

endmodule

bind floppy_mailbox_command_engine fmce_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/floppy_mailbox_command_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox command engine testbench
// Drives bus accesses, drive events, ticks and transfer completions through
// the item channel, predicts every result from a behavioural copy of the
// mailbox and checks each one in order, over several idling phases and
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module floppy_mailbox_command_engine_tb;
  import fmce_pkg::*;

  localparam int unsigned RamSize = 1024;
  localparam int unsigned CycleLimit = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_taken = 1'b0;

  floppy_mailbox_command_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mailbox shadow: RAM, interrupt, drive and timer state.
  logic [7:0] mb_ram [RamSize];
  logic mb_irq, mb_disk, mb_double, mb_pend, mb_last_wr;
  logic [15:0] mb_count, mb_delay;

  in_t item_queue[$];
  out_t result_queue[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  int n_requests = 0, n_fires = 0, n_items = 0;

  function automatic logic [7:0] mb_get(int unsigned idx);
    return idx < RamSize ? mb_ram[idx] : 8'hFF;
  endfunction

  function automatic void mb_put(int unsigned idx, logic [7:0] v);
    if (idx < RamSize) mb_ram[idx] = v;
  endfunction

  function automatic void mb_reset();
    foreach (mb_ram[i]) mb_ram[i] = 8'h00;
    mb_irq = 0; mb_disk = 0; mb_double = 0; mb_pend = 0; mb_last_wr = 0;
    mb_count = 0; mb_delay = CompleteDelayRst;
    mb_put(AdrB196, SweepB196);
    mb_put(AdrB254, SweepB254);
  endfunction

  function automatic void mb_media();
    mb_put(AdrMedia, mb_disk ? (mb_double ? 8'h02 : 8'h01) : 8'h00);
    mb_put(AdrPresent, mb_disk ? 8'h01 : 8'h00);
  endfunction

  // Execute command: disk and address checks, then request, eject or plain status.
  function automatic void mb_exec(ref out_t r);
    logic [7:0] sub, sec, trk, sd;
    sub = mb_get(AdrSub);
    sec = mb_get(AdrSector);
    trk = mb_get(AdrTrack);
    sd = mb_get(AdrSide);
    if (!mb_disk) mb_put(AdrStatus, StNoDisk);
    else if (trk > MaxTrack || sec >= ZoneBase - (trk >> 4)) mb_put(AdrStatus, StBadAddr);
    else if (sub == SubRead || sub == SubRdTag || sub == SubWrite) begin
      r.disk_request = 1;
      r.request_write = (sub == SubWrite);
      r.request_track = trk[6:0];
      r.request_side = sd[0];
      r.request_sector = sec[3:0];
      mb_last_wr = (sub == SubWrite);
      n_requests++;
    end else if (sub == SubEject) begin
      mb_disk = 0;
      mb_media();
      mb_put(AdrEvent, 8'h00);
      mb_put(AdrStatus, StOk);
    end else mb_put(AdrStatus, StOk);
    mb_put(AdrCmd, 8'h00);
    mb_count = mb_delay;
    mb_pend = 1;
  endfunction

  function automatic out_t mb_predict(in_t it);
    out_t r;
    int unsigned idx;
    logic [7:0] ev;
    r = '0;
    idx = 32'(it.bus_offset >> 1);
    case (cmd_t'(it.cmd))
      CMD_READ: r.read_data = mb_get(idx);
      CMD_WRITE: if (idx < RamSize) begin
        mb_ram[idx] = it.write_data;
        if (idx == AdrCmd && it.write_data != 0) begin
          case (it.write_data)
            MbExec: mb_exec(r);
            MbStatClr: begin
              mb_put(AdrStatus, StOk); mb_put(AdrCmd, 8'h00); mb_irq = 1;
            end
            MbClrSix: begin
              mb_put(AdrSix, 8'h00); mb_put(AdrStatus, StOk); mb_put(AdrCmd, 8'h00);
            end
            MbIrqClr: begin
              mb_put(AdrEvent, 8'h00); mb_put(AdrCmd, 8'h00); mb_irq = 0;
            end
            MbIrqSet: begin
              mb_put(AdrCmd, 8'h00); mb_irq = 1;
            end
            default: mb_put(AdrCmd, 8'h00);
          endcase
        end
      end
      CMD_INSERT: begin
        mb_disk = 1; mb_double = it.two_sided;
        mb_media();
        mb_put(AdrEvent, mb_get(AdrEvent) | EvInsert);
        mb_irq = 1;
      end
      CMD_EJECT: begin
        mb_disk = 0; mb_media(); mb_put(AdrEvent, 8'h00);
      end
      CMD_TICK: if (mb_pend) begin
        if (mb_count <= 1) begin
          ev = (mb_get(AdrCtl) & 8'h88) >> 1;
          if (ev & 8'h70) ev |= 8'h80;
          if (ev == 0) ev = EvInsert;
          mb_put(AdrEvent, mb_get(AdrEvent) | ev);
          mb_irq = 1; mb_pend = 0; mb_count = 0;
          n_fires++;
        end else mb_count--;
      end
      CMD_DONE: mb_put(AdrStatus, it.transfer_ok ? StOk : (mb_last_wr ? StWrFail : StBadAddr));
      default: ;
    endcase
    r.irq_line = mb_irq;
    r.media_present = mb_disk;
    return r;
  endfunction

  // Driver: inputs change on the falling edge; hold the item until accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // accepted at the previous rising edge: predict, then advance
        result_queue.push_back(mb_predict(in_item));
        n_items++;
        void'(item_queue.pop_front());
      end
      if (in_valid && !in_taken) begin
        // hold
      end else if (item_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_item <= item_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        out_t e;
        e = result_queue.pop_front();
        if (e.read_data != out_item.read_data || e.irq_line != out_item.irq_line ||
            e.disk_request != out_item.disk_request ||
            e.request_write != out_item.request_write ||
            e.request_track != out_item.request_track ||
            e.request_side != out_item.request_side ||
            e.request_sector != out_item.request_sector ||
            e.media_present != out_item.media_present) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, e, out_item);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_t mk(cmd_t c, int unsigned off, logic [7:0] d, logic two = 0,
                             logic ok = 0);
    in_t it;
    it.cmd = c; it.bus_offset = off[15:0]; it.write_data = d;
    it.two_sided = two; it.transfer_ok = ok;
    return it;
  endfunction

  function automatic void wr(int unsigned adr, logic [7:0] d);
    item_queue.push_back(mk(CMD_WRITE, adr * 2 + $urandom_range(1), d));
  endfunction

  // A well-formed command sequence: set up the block, issue, finish it off.
  function automatic void command_sequence();
    logic [7:0] trk, sec;
    int k;
    trk = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(79));
    sec = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(11));
    if ($urandom_range(5) == 0)
      item_queue.push_back(mk(CMD_INSERT, $urandom, 8'h00, 1'($urandom)));
    wr(AdrSub, ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
    wr(AdrSide, 8'($urandom));
    wr(AdrSector, sec);
    wr(AdrTrack, trk);
    if ($urandom_range(1)) wr(AdrCtl, 8'($urandom));
    wr(AdrCmd, MbExec);
    if ($urandom_range(2) != 0)
      item_queue.push_back(mk(CMD_DONE, $urandom, 8'($urandom), 1'($urandom),
                              1'($urandom)));
    k = $urandom_range(6);
    repeat (k) item_queue.push_back(mk(CMD_TICK, $urandom, 8'($urandom)));
    item_queue.push_back(mk(CMD_READ, AdrEvent * 2, 0));
    item_queue.push_back(mk(CMD_READ, AdrStatus * 2, 0));
    if ($urandom_range(2) == 0) wr(AdrCmd, MbIrqClr);
  endfunction

  function automatic void random_item();
    int unsigned sel, adr;
    cmd_t c;
    sel = $urandom_range(99);
    adr = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2047);
    if (sel < 5) c = CMD_INSERT;
    else if (sel < 8) c = CMD_EJECT;
    else if (sel < 20) c = CMD_TICK;
    else if (sel < 26) c = CMD_DONE;
    else if (sel < 60) c = CMD_READ;
    else c = CMD_WRITE;
    if (c == CMD_WRITE && $urandom_range(3) == 0) begin
      // mailbox command byte, mostly known codes
      case ($urandom_range(5))
        0: wr(AdrCmd, MbExec);
        1: wr(AdrCmd, MbStatClr);
        2: wr(AdrCmd, MbClrSix);
        3: wr(AdrCmd, MbIrqClr);
        4: wr(AdrCmd, MbIrqSet);
        default: wr(AdrCmd, 8'($urandom));
      endcase
    end else item_queue.push_back(mk(c, adr, 8'($urandom), 1'($urandom), 1'($urandom)));
  endfunction

  task automatic drain();
    while (item_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Registers are written only with the block idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgCompleteDelay) mb_delay = v;
    else mb_put(AdrRomId, v[7:0]);
  endtask

  task automatic run_phase(int n, int si, int ri);
    send_idle = si; recv_idle = ri;
    while (n > 0) begin
      if ($urandom_range(99) < 70) begin
        command_sequence(); n -= 12;
      end else begin
        random_item(); n--;
      end
    end
    drain();
  endtask

  initial begin
    mb_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Directed: reset bytes, range extremes, every command and special case.
    item_queue.push_back(mk(CMD_READ, AdrB196 * 2, 0));
    item_queue.push_back(mk(CMD_READ, AdrB254 * 2 + 1, 0));
    item_queue.push_back(mk(CMD_READ, 16'hFFFF, 0));
    item_queue.push_back(mk(CMD_WRITE, 16'hFFFF, 8'hFF, 1, 1));
    item_queue.push_back(mk(CMD_READ, 16'h0000, 0));
    wr(AdrCmd, MbExec);                        // no disk
    item_queue.push_back(mk(CMD_DONE, 0, 0, 0, 0)); // stray done after reset
    item_queue.push_back(mk(CMD_INSERT, 0, 0, 1, 0));
    wr(AdrSector, 8'd7); wr(AdrTrack, 8'd79); wr(AdrSide, 8'hFF);
    wr(AdrCmd, MbExec);                        // top track, last zone
    wr(AdrTrack, 8'd80); wr(AdrCmd, MbExec);   // track out of range
    item_queue.push_back(mk(CMD_WRITE, 2 * 7, 8'hAA)); // unused byte
    item_queue.push_back(mk(cmd_t'(3'd6), 0, 0));
    item_queue.push_back(mk(cmd_t'(3'd7), 16'hFFFF, 8'hFF, 1, 1));
    wr(AdrCmd, MbStatClr); wr(AdrCmd, MbClrSix); wr(AdrCmd, MbIrqClr);
    wr(AdrCmd, MbIrqSet); wr(AdrCmd, 8'h42);
    item_queue.push_back(mk(CMD_EJECT, 0, 0));
    drain();

    write_reg(CfgCompleteDelay, 16'd0);        // zero acts as one
    write_reg(CfgDiskRomId, 16'h00FF);
    item_queue.push_back(mk(CMD_INSERT, 0, 0, 0, 0));
    wr(AdrCtl, 8'hF8); wr(AdrSub, SubWrite); wr(AdrTrack, 0); wr(AdrSector, 11);
    wr(AdrCmd, MbExec);
    item_queue.push_back(mk(CMD_DONE, 0, 0, 0, 0));
    item_queue.push_back(mk(CMD_TICK, 0, 0));
    item_queue.push_back(mk(CMD_READ, AdrEvent * 2, 0));
    item_queue.push_back(mk(CMD_READ, AdrRomId * 2, 0));
    run_phase(110, 0, 0);

    write_reg(CfgCompleteDelay, 16'd3);
    write_reg(CfgDiskRomId, 16'h005A);
    run_phase(110, 65, 0);
    write_reg(CfgCompleteDelay, 16'd1);
    run_phase(110, 0, 65);
    write_reg(CfgCompleteDelay, 16'd5);
    write_reg(CfgDiskRomId, 16'h0000);
    // long receiver hold-off while items keep coming
    hold_off = 400;
    run_phase(110, 28, 28);
    write_reg(CfgCompleteDelay, 16'hFFFF);
    run_phase(60, 0, 0);
    write_reg(CfgCompleteDelay, 16'd2);
    run_phase(60, 65, 65);

    $display("run covered %0d items, %0d sector requests, %0d timer completions",
             n_items, n_requests, n_fires);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/fmce_pkg.sv
hw/rtl/fmce_front.sv
hw/rtl/fmce_engine.sv
hw/rtl/floppy_mailbox_command_engine.sv
hw/rtl/fmce_checker.sv
tb/sv/floppy_mailbox_command_engine_tb.sv
